[rtl/fselt_pkg.sv]
// Package for the shared/exclusive lock table: widths, codes, FSM state type and memory request type.
// No dependencies.
package fselt_pkg;
    localparam int NUM_ITEMS   = 64;
    localparam int QUEUE_DEPTH = 16;
    localparam int ITEM_W      = 6;
    localparam int CLIENT_W    = 4;
    localparam int POS_W       = $clog2(QUEUE_DEPTH);
    localparam int LEN_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W      = ITEM_W + POS_W;
    localparam int ENTRY_W     = CLIENT_W + 1;

    localparam logic [1:0] MODE_SHARED  = 2'd0;
    localparam logic [1:0] MODE_EXCL    = 2'd1;
    localparam logic [1:0] MODE_RELEASE = 2'd2;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;

    localparam logic [1:0] RK_GRANTED   = 2'd0;
    localparam logic [1:0] RK_RELEASED  = 2'd1;
    localparam logic [1:0] RK_EMPTY_ERR = 2'd2;
    localparam logic [1:0] RK_FULL_ERR  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEN,
        ST_SEARCH,
        ST_SHIFT,
        ST_GRANT
    } state_t;

    typedef struct packed {
        logic                we;
        logic [ADDR_W-1:0]   waddr;
        logic [ENTRY_W-1:0]  wdata;
        logic [ADDR_W-1:0]   raddr;
    } mem_req_t;
endpackage

[rtl/fselt_entry_ram.sv]
// Queue entry store: one write port, one registered read port.
// Depends on fselt_pkg.
module fselt_entry_ram (
    input  logic                      clk,
    input  fselt_pkg::mem_req_t       req,
    output logic [fselt_pkg::ENTRY_W-1:0] rdata
);
    import fselt_pkg::*;

    logic [ENTRY_W-1:0] mem [NUM_ITEMS*QUEUE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata <= mem[req.raddr];
    end
endmodule

[rtl/fselt_len_ram.sv]
// Queue length store with per-item valid bits so reset reads as empty.
// Depends on fselt_pkg.
module fselt_len_ram (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          we,
    input  logic [fselt_pkg::ITEM_W-1:0]  addr,
    input  logic [fselt_pkg::LEN_W-1:0]   wdata,
    output logic [fselt_pkg::LEN_W-1:0]   rdata
);
    import fselt_pkg::*;

    logic [LEN_W-1:0]     mem [NUM_ITEMS];
    logic [NUM_ITEMS-1:0] vld_reg;
    logic [LEN_W-1:0]     q_reg;
    logic                 qv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            qv_reg  <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                vld_reg[addr] <= 1'b1;
            end
            qv_reg <= vld_reg[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        q_reg <= mem[addr];
    end

    assign rdata = qv_reg ? q_reg : '0;
endmodule

[rtl/fifo_shared_exclusive_lock_table.sv]
// Top level of the FIFO shared/exclusive lock table: sequencer plus two memories.
// Depends on fselt_pkg, fselt_entry_ram and fselt_len_ram.
//
// Usage: raise start with mode, item and client_id while busy is low; the
// request is taken at that edge and busy rises (mode 3 is dropped at once).
// Each response is held for one cycle with strobe high on response_kind,
// target_client and last; last marks the final response of a request. A
// release by a client not in the queue gives no response.
// Steps after the accepting edge: the length is read first, so a full or
// non-empty acquire ends there and an acquire into an empty queue goes on
// to a grant. A release searches the entries up to the match, then moves
// the entries behind it down; a miss searches every entry. Re-granting
// from a new front walks the granted entries and then closes the run,
// unless the front is exclusive or alone. The longest request, a front
// release from a full queue of shared entries, is bounded by the single
// read port of the entry memory. Each response is registered and leaves in
// the cycle after the cycle that makes it, so the last one may overlap the
// first idle cycle. One request at a time.
// Reset clears the length valid bits, so every queue reads empty; the
// entry memory needs no clearing. The receiver cannot stall: responses
// are strobed and must be taken as they come.
module fifo_shared_exclusive_lock_table (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      mode,
    input  logic [fselt_pkg::ITEM_W-1:0]    item,
    input  logic [fselt_pkg::CLIENT_W-1:0]  client_id,
    output logic                            strobe,
    output logic [1:0]                      response_kind,
    output logic [fselt_pkg::CLIENT_W-1:0]  target_client,
    output logic                            last
);
    import fselt_pkg::*;

    state_t state_reg, state_next;

    // held request
    logic [1:0]          mode_reg;
    logic [ITEM_W-1:0]   item_reg;
    logic [CLIENT_W-1:0] client_reg;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [LEN_W-1:0]    idx_reg, idx_next;  // entry whose data arrives now
    logic                first_reg, first_next; // first grant of a run
    logic [CLIENT_W-1:0] pend_reg, pend_next;   // grant waiting for its last bit

    // response register
    logic                strobe_reg, strobe_next;
    logic [1:0]          kind_reg, kind_next;
    logic [CLIENT_W-1:0] tgt_reg, tgt_next;
    logic                last_reg, last_next;

    mem_req_t           ereq;
    logic [ENTRY_W-1:0] edata;
    logic               len_we;
    logic [LEN_W-1:0]   len_wdata, len_rdata;

    // forwarded copy of a write that hit the address read in the same cycle
    logic [ENTRY_W-1:0] fwd_reg;
    logic               fwd_hit_reg;
    logic [ENTRY_W-1:0] ent_data;

    fselt_entry_ram u_entry (
        .clk   (clk),
        .req   (ereq),
        .rdata (edata)
    );

    fselt_len_ram u_len (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (len_we),
        .addr  (start && !busy ? item : item_reg),
        .wdata (len_wdata),
        .rdata (len_rdata)
    );

    logic accept;
    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);

    logic [LEN_W-1:0]  idx_inc;
    logic [POS_W-1:0]  idx_pos, inc_pos;
    logic              ent_excl;
    logic [CLIENT_W-1:0] ent_client;
    assign idx_inc    = idx_reg + 1'b1;
    assign idx_pos    = idx_reg[POS_W-1:0];
    assign inc_pos    = idx_inc[POS_W-1:0];
    assign ent_data   = fwd_hit_reg ? fwd_reg : edata;
    assign ent_excl   = ent_data[ENTRY_W-1];
    assign ent_client = ent_data[CLIENT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg   <= mode;
            item_reg   <= item;
            client_reg <= client_id;
        end
        len_reg   <= len_next;
        idx_reg   <= idx_next;
        first_reg <= first_next;
        pend_reg  <= pend_next;
        kind_reg  <= kind_next;
        tgt_reg   <= tgt_next;
        last_reg  <= last_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && mode != MODE_UNUSED && {1'b0, item} < NUM_ITEMS)
                begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN:
            begin
                if (mode_reg != MODE_RELEASE)
                begin
                    state_next = (len_rdata == LEN_W'(0)) ? ST_GRANT : ST_IDLE;
                end
                else
                begin
                    state_next = (len_rdata == LEN_W'(0)) ? ST_IDLE : ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (ent_client == client_reg)
                begin
                    state_next = (idx_inc < len_reg) ? ST_SHIFT
                               : ST_IDLE;
                    if (idx_inc >= len_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (idx_inc >= len_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SHIFT:
            begin
                if (idx_inc >= len_reg)
                begin
                    state_next = (first_reg) ? ST_GRANT : ST_IDLE;
                end
            end
            ST_GRANT:
            begin
                if (first_reg)
                begin
                    if (ent_excl || idx_inc >= len_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (idx_reg >= len_reg || ent_excl)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        len_next    = len_reg;
        idx_next    = idx_reg;
        first_next  = first_reg;
        pend_next   = pend_reg;
        strobe_next = 1'b0;
        kind_next   = kind_reg;
        tgt_next    = tgt_reg;
        last_next   = 1'b0;
        len_we      = 1'b0;
        len_wdata   = len_reg;
        ereq.we     = 1'b0;
        ereq.waddr  = {item_reg, idx_pos};
        ereq.wdata  = edata;
        ereq.raddr  = {item_reg, POS_W'(0)};
        unique case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
            end
            ST_LEN:
            begin
                len_next = len_rdata;
                idx_next = '0;
                if (mode_reg != MODE_RELEASE)
                begin
                    if (len_rdata >= LEN_W'(QUEUE_DEPTH))
                    begin
                        strobe_next = 1'b1;
                        kind_next   = RK_FULL_ERR;
                        tgt_next    = client_reg;
                        last_next   = 1'b1;
                    end
                    else
                    begin
                        // append at the tail
                        ereq.we    = 1'b1;
                        ereq.waddr = {item_reg, len_rdata[POS_W-1:0]};
                        ereq.wdata = {mode_reg == MODE_EXCL, client_reg};
                        len_we     = 1'b1;
                        len_wdata  = len_rdata + 1'b1;
                        len_next   = LEN_W'(1);
                        first_next = 1'b1;
                    end
                end
                else if (len_rdata == LEN_W'(0))
                begin
                    strobe_next = 1'b1;
                    kind_next   = RK_EMPTY_ERR;
                    tgt_next    = client_reg;
                    last_next   = 1'b1;
                end
            end
            ST_SEARCH:
            begin
                ereq.raddr = {item_reg, inc_pos};
                idx_next   = idx_inc;
                if (ent_client == client_reg)
                begin
                    // found: drop this entry, report release
                    len_we      = 1'b1;
                    len_wdata   = len_reg - 1'b1;
                    first_next  = (idx_reg == LEN_W'(0)) && (len_reg > LEN_W'(1));
                    strobe_next = 1'b1;
                    kind_next   = RK_RELEASED;
                    tgt_next    = client_reg;
                    last_next   = !((idx_reg == LEN_W'(0)) && (len_reg > LEN_W'(1)));
                    if (idx_inc >= len_reg)
                    begin
                        idx_next = '0;
                    end
                end
            end
            ST_SHIFT:
            begin
                // data of entry idx arrives; write it one place down
                ereq.we    = 1'b1;
                ereq.waddr = {item_reg, POS_W'(idx_reg - 1'b1)};
                ereq.wdata = edata;
                ereq.raddr = {item_reg, inc_pos};
                idx_next   = idx_inc;
                if (idx_inc >= len_reg)
                begin
                    len_next   = len_reg - 1'b1;
                    ereq.raddr = {item_reg, POS_W'(0)};
                    idx_next   = '0;
                    // if this write lands on the new front, it is forwarded
                end
            end
            ST_GRANT:
            begin
                // hold each grant for one entry so its last bit sees what follows
                ereq.raddr = {item_reg, inc_pos};
                idx_next   = idx_inc;
                first_next = 1'b0;
                pend_next  = ent_client;
                if (first_reg)
                begin
                    if (ent_excl || idx_inc >= len_reg)
                    begin
                        strobe_next = 1'b1;
                        kind_next   = RK_GRANTED;
                        tgt_next    = ent_client;
                        last_next   = 1'b1;
                    end
                end
                else
                begin
                    strobe_next = 1'b1;
                    kind_next   = RK_GRANTED;
                    tgt_next    = pend_reg;
                    last_next   = (idx_reg >= len_reg) || ent_excl;
                end
            end
            default: ;
        endcase
    end

    // Forward a same-cycle write so the next read sees new data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            fwd_hit_reg <= ereq.we && (ereq.waddr == ereq.raddr);
        end
    end
    always_ff @(posedge clk)
    begin
        fwd_reg <= ereq.wdata;
    end

    // A shared run ends at the first exclusive entry or at the tail; the
    // grant held back at that point carries last.
    assign strobe        = strobe_reg;
    assign response_kind = kind_reg;
    assign target_client = tgt_reg;
    assign last          = last_reg;

`ifndef SYNTH
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> !$past(accept)) else $error("response too early");
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && !$past(busy)) |-> !strobe)
        else $error("response while idle");
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_we |-> len_wdata <= LEN_W'(QUEUE_DEPTH)) else $error("length overflow");
`endif
endmodule

[sim/tb_top.sv]
// Testbench for the FIFO shared/exclusive lock table: predicts grants, releases and
// errors per request and checks every strobed response. Depends on fselt_pkg and the RTL.
`timescale 1ns / 100ps

module tb_top;
    import fselt_pkg::*;

    typedef struct {
        logic [1:0]          kind;
        logic [CLIENT_W-1:0] client;
        logic                last;
    } response_t;

    typedef struct {
        logic [CLIENT_W-1:0] client;
        logic                excl;
    } waiter_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [1:0]          mode;
    logic [ITEM_W-1:0]   item;
    logic [CLIENT_W-1:0] client_id;
    logic                strobe;
    logic [1:0]          response_kind;
    logic [CLIENT_W-1:0] target_client;
    logic                last;

    // Predicted lock table state: one waiting line per item.
    waiter_t   waiters [NUM_ITEMS][$];
    // Responses predicted but not yet seen on the ports, oldest first.
    response_t pending_responses[$];
    int        mismatches;
    int        responses_seen;
    int        requests_sent;

    fifo_shared_exclusive_lock_table u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .item          (item),
        .client_id     (client_id),
        .strobe        (strobe),
        .response_kind (response_kind),
        .target_client (target_client),
        .last          (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // Grant the front waiter and, when it is shared, every shared waiter behind it up to the first exclusive one.
    function automatic void predict_front_grants(input int it);
        int k;
        response_t r;
        if (waiters[it].size() == 0)
            return;
        for (k = 0; k < waiters[it].size(); k++)
        begin
            if (k > 0 && waiters[it][k].excl)
                break;
            r.kind = RK_GRANTED;
            r.client = waiters[it][k].client;
            r.last = 1'b0;
            pending_responses.insert(pending_responses.size(), r);
            if (waiters[it][0].excl)
                break;
        end
    endfunction

    // Work out the responses to one request and update the predicted table.
    function automatic void predict_lock_request(input logic [1:0] m,
                                                 input logic [ITEM_W-1:0] it,
                                                 input logic [CLIENT_W-1:0] cl);
        int before_count;
        int pos;
        int k;
        waiter_t w;
        response_t r;
        before_count = pending_responses.size();
        if (m == MODE_SHARED || m == MODE_EXCL)
        begin
            if (waiters[it].size() >= QUEUE_DEPTH)
            begin
                r.kind = RK_FULL_ERR;
                r.client = cl;
                r.last = 1'b0;
                pending_responses.insert(pending_responses.size(), r);
            end
            else
            begin
                w.client = cl;
                w.excl = (m == MODE_EXCL);
                waiters[it].insert(waiters[it].size(), w);
                if (waiters[it].size() == 1)
                    predict_front_grants(it);
            end
        end
        else if (m == MODE_RELEASE)
        begin
            if (waiters[it].size() == 0)
            begin
                r.kind = RK_EMPTY_ERR;
                r.client = cl;
                r.last = 1'b0;
                pending_responses.insert(pending_responses.size(), r);
            end
            else
            begin
                pos = -1;
                for (k = 0; k < waiters[it].size(); k++)
                begin
                    if (waiters[it][k].client == cl)
                    begin
                        pos = k;
                        break;
                    end
                end
                if (pos >= 0)
                begin
                    waiters[it].delete(pos);
                    r.kind = RK_RELEASED;
                    r.client = cl;
                    r.last = 1'b0;
                    pending_responses.insert(pending_responses.size(), r);
                    if (pos == 0)
                        predict_front_grants(it);
                end
            end
        end
        if (pending_responses.size() > before_count)
            pending_responses[$].last = 1'b1;
    endfunction

    // Sample each strobed response at the rising edge and compare with the oldest prediction.
    always @(posedge clk)
    begin
        response_t want;
        if (rst_n && strobe)
        begin
            responses_seen++;
            if (pending_responses.size() == 0)
                report_mismatch($sformatf("unexpected response kind %0d client %0d",
                                          response_kind, target_client));
            else
            begin
                want = pending_responses.pop_front();
                if (response_kind !== want.kind)
                    report_mismatch($sformatf("kind %0d, want %0d", response_kind, want.kind));
                if (target_client !== want.client)
                    report_mismatch($sformatf("client %0d, want %0d",
                                              target_client, want.client));
                if (last !== want.last)
                    report_mismatch($sformatf("last %0d, want %0d", last, want.last));
            end
        end
    end

    // Send one request: idle a random gap, raise start, hold until accepted.
    task automatic send_request(input logic [1:0] m, input logic [ITEM_W-1:0] it,
                                input logic [CLIENT_W-1:0] cl);
        int gap;
        gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        repeat (gap) @(negedge clk);
        start = 1'b1;
        mode = m;
        item = it;
        client_id = cl;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        predict_lock_request(m, it, cl);
        requests_sent++;
        @(negedge clk);
        start = 1'b0;
        mode = 2'($urandom_range(0, 3));
        item = ITEM_W'($urandom);
        client_id = CLIENT_W'($urandom);
    endtask

    // Hold until every predicted response has arrived, then let the block settle.
    task automatic drain_responses;
        while (pending_responses.size() != 0)
            @(negedge clk);
        repeat (2 * QUEUE_DEPTH + 8) @(negedge clk);
    endtask

    // Directed: empty release, ignored mode, shared run, exclusive wait, absent release, repeat client, fill to full.
    task automatic test_directed;
        int k;
        send_request(MODE_RELEASE, 6'd0, 4'd0);
        send_request(MODE_UNUSED, 6'd0, 4'd15);
        send_request(MODE_SHARED, 6'd0, 4'd1);
        send_request(MODE_SHARED, 6'd0, 4'd2);
        send_request(MODE_EXCL, 6'd0, 4'd3);
        send_request(MODE_SHARED, 6'd0, 4'd4);
        send_request(MODE_RELEASE, 6'd0, 4'd9);
        send_request(MODE_RELEASE, 6'd0, 4'd1);
        send_request(MODE_RELEASE, 6'd0, 4'd2);
        send_request(MODE_RELEASE, 6'd0, 4'd3);
        send_request(MODE_RELEASE, 6'd0, 4'd4);
        for (k = 0; k < QUEUE_DEPTH + 1; k++)
            send_request(MODE_SHARED, 6'd63, 4'd15);
        drain_responses();
        // Releasing the whole run walks grants again from each new front.
        for (k = 0; k < QUEUE_DEPTH; k++)
            send_request(MODE_RELEASE, 6'd63, 4'd15);
    endtask

    // Random: mostly acquire/release traffic on a few items, with some noise.
    task automatic test_random(input int count);
        int n;
        int sel;
        logic [1:0] m;
        logic [ITEM_W-1:0] it;
        for (n = 0; n < count; n++)
        begin
            sel = $urandom_range(0, 19);
            it = (sel < 16) ? ITEM_W'($urandom_range(0, 3)) : ITEM_W'($urandom);
            if (sel == 19)
                m = MODE_UNUSED;
            else if (sel < 8)
                m = 2'($urandom_range(0, 1));
            else
                m = MODE_RELEASE;
            send_request(m, it, (sel < 12) ? CLIENT_W'($urandom_range(0, 5))
                                           : CLIENT_W'($urandom));
            if (n == count / 2)
                drain_responses();
        end
    endtask

    initial
    begin
        mismatches = 0;
        responses_seen = 0;
        requests_sent = 0;
        rst_n = 1'b0;
        start = 1'b0;
        mode = MODE_SHARED;
        item = '0;
        client_id = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_random(450);
        drain_responses();
        $display("Covered %0d requests and %0d responses: shared runs, exclusive waits,",
                 requests_sent, responses_seen);
        $display("full and empty queue errors, absent releases and ignored modes.");
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
